// ===== hw/rtl/utt_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder: queue command type, queue sizing,
// surrogate and range constants, and the byte formatting function.
// No dependencies.
`default_nettype none

package utt_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	localparam logic [20:0] LIM_ONE   = 21'h00080;
	localparam logic [20:0] LIM_TWO   = 21'h00800;

	localparam logic [7:0] LEAD_TWO   = 8'hC0;
	localparam logic [7:0] LEAD_THREE = 8'hE0;
	localparam logic [7:0] LEAD_FOUR  = 8'hF0;
	localparam logic [7:0] CONT_MARK  = 8'h80;

	typedef enum logic [1:0] {
		LEN_ONE   = 2'd0,
		LEN_TWO   = 2'd1,
		LEN_THREE = 2'd2,
		LEN_FOUR  = 2'd3
	} len_t;

	typedef struct packed {
		logic [20:0] cp;
		len_t        len;
	} cmd_t;

	function automatic logic [5:0] utt_group(input logic [20:0] cp, input logic [1:0] k);
		logic [5:0] g;
		unique case (k)
			2'd0: g = cp[5:0];
			2'd1: g = cp[11:6];
			2'd2: g = cp[17:12];
			default: g = {3'b000, cp[20:18]};
		endcase
		return g;
	endfunction

	function automatic logic [7:0] utt_byte(input cmd_t cmd, input logic [1:0] idx);
		logic [7:0] b;
		logic [1:0] k;
		k = 2'(cmd.len - idx);
		if (idx != 2'd0) begin
			b = CONT_MARK | {2'b00, utt_group(cmd.cp, k)};
		end else begin
			unique case (cmd.len)
				LEN_ONE:   b = {1'b0, cmd.cp[6:0]};
				LEN_TWO:   b = LEAD_TWO | {3'b000, cmd.cp[10:6]};
				LEN_THREE: b = LEAD_THREE | {4'b0000, cmd.cp[15:12]};
				default:   b = LEAD_FOUR | {5'b00000, cmd.cp[20:18]};
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utt_front.sv =====
// Front end: accepts code units, pairs surrogates and classifies each code point
// into a queue command with its encoded length. Depends on utt_pkg.
`default_nettype none

module utt_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [15:0]  code_unit,
	input  wire logic         end_of_text,
	input  wire logic         q_full,
	output logic              q_push,
	output utt_pkg::cmd_t     q_cmd
);
	import utt_pkg::*;

	logic       high_pending_q;
	logic [9:0] high_bits_q;
	logic       fire;
	logic       is_high;
	logic       is_low;
	logic       pair;
	logic [10:0] plane;

	assign in_stall = q_full;
	assign fire     = in_valid && !q_full;
	assign is_high  = code_unit[15:10] == HIGH_SURR_TAG;
	assign is_low   = code_unit[15:10] == LOW_SURR_TAG;
	assign pair     = high_pending_q && is_low;
	assign plane    = {1'b0, high_bits_q} + 11'h040;

	always_comb begin
		q_cmd = '0;
		if (pair) begin
			q_cmd.cp  = {plane, code_unit[9:0]};
			q_cmd.len = LEN_FOUR;
		end else begin
			q_cmd.cp = {5'b00000, code_unit};
			if (q_cmd.cp < LIM_ONE) begin
				q_cmd.len = LEN_ONE;
			end else if (q_cmd.cp < LIM_TWO) begin
				q_cmd.len = LEN_TWO;
			end else begin
				q_cmd.len = LEN_THREE;
			end
		end
	end

	assign q_push = fire && (pair || (!is_high && !is_low));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			high_bits_q    <= '0;
		end else if (fire) begin
			high_pending_q <= is_high && !end_of_text;
			high_bits_q    <= (is_high && !end_of_text) ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/utt_queue.sv =====
// Short command queue between the front end and the byte serialiser.
// Depends on utt_pkg.
`default_nettype none

module utt_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire utt_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output utt_pkg::cmd_t      pop_cmd,
	output logic               empty
);
	import utt_pkg::*;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = count_q == QUEUE_CW'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/utt_back.sv =====
// Back end: takes queued commands and emits their UTF-8 bytes one per cycle, unless
// out_stall holds them, through an output register. Depends on utt_pkg.
`default_nettype none

module utt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire utt_pkg::cmd_t q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         utf8_byte,
	output logic               run_last
);
	import utt_pkg::*;

	cmd_t       cmd_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       adv;
	logic       busy_last;

	assign adv       = !valid_q || !out_stall;
	assign q_pop     = adv && !busy_q && !q_empty;
	assign busy_last = idx_q == cmd_q.len;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				byte_q <= utt_byte(cmd_q, idx_q);
				last_q <= busy_last;
			end else begin
				byte_q <= utt_byte(q_cmd, 2'd0);
				last_q <= q_cmd.len == LEN_ONE;
				cmd_q  <= q_cmd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
		end else if (adv) begin
			if (busy_q) begin
				valid_q <= 1'b1;
				busy_q  <= !busy_last;
				idx_q   <= idx_q + 1'b1;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				busy_q  <= q_cmd.len != LEN_ONE;
				idx_q   <= 2'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign utf8_byte = byte_q;
	assign run_last  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utf16_to_utf8_transcoder_core.sv =====
// UTF-16 to UTF-8 transcoder top level: front end, command queue and byte serialiser.
// Depends on utt_pkg, utt_front, utt_queue and utt_back.
//
// One code unit is accepted per cycle while the four-entry command queue has room;
// the serialiser emits one UTF-8 byte per cycle unless out_stall holds it, so a code
// point yields one to four bytes on the output and the sustained rate is set by the
// byte count. A high surrogate is held and produces no bytes; the following low
// surrogate yields four bytes. Dropped units are accepted and produce no output.
// run_last marks the final byte of each code point.
`default_nettype none

module utf16_to_utf8_transcoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       utf8_byte,
	output logic             run_last
);
	import utt_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	utt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	utt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	utt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.utf8_byte (utf8_byte),
		.run_last  (run_last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into a full queue");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid && utf8_byte[7:6] == 2'b10)
		else $error("run broken or next byte not a continuation byte");

	a_lead_is_last_only_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last && utf8_byte[7] |-> utf8_byte[7:6] == 2'b10)
		else $error("multi-byte lead marked as last byte");

endmodule

`default_nettype wire

// ===== sim/utt_stream_checker.sv =====
// Checker for the UTF-16 to UTF-8 transcoder: watches both channels, predicts the bytes
// of each accepted code unit and compares them with the accepted output bytes in order.
// Stands alone; hands a mismatch count and the number of bytes still owed to the top.
module utt_stream_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        end_of_text,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  utf8_byte,
	input  wire logic        run_last,
	output int               mismatches,
	output int               bytes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] octet;
		logic       last_flag;
	} utf8_out_t;

	utf8_out_t   owed_bytes[$];
	logic        surr_held = 1'b0;
	logic [9:0]  surr_bits = '0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic void add_octet(input logic [7:0] b, input logic last_flag);
		utf8_out_t e;
		e.octet = b;
		e.last_flag = last_flag;
		owed_bytes.insert(owed_bytes.size(), e);
	endfunction

	function automatic void encode_point(input logic [20:0] cp);
		if (cp < 21'h00080) begin
			add_octet(cp[7:0], 1'b1);
		end else if (cp < 21'h00800) begin
			add_octet(8'hC0 | {3'b000, cp[10:6]}, 1'b0);
			add_octet(8'h80 | {2'b00, cp[5:0]}, 1'b1);
		end else if (cp < 21'h10000) begin
			add_octet(8'hE0 | {4'b0000, cp[15:12]}, 1'b0);
			add_octet(8'h80 | {2'b00, cp[11:6]}, 1'b0);
			add_octet(8'h80 | {2'b00, cp[5:0]}, 1'b1);
		end else begin
			add_octet(8'hF0 | {5'b00000, cp[20:18]}, 1'b0);
			add_octet(8'h80 | {2'b00, cp[17:12]}, 1'b0);
			add_octet(8'h80 | {2'b00, cp[11:6]}, 1'b0);
			add_octet(8'h80 | {2'b00, cp[5:0]}, 1'b1);
		end
	endfunction

	function automatic void predict_unit(input logic [15:0] u, input logic eot);
		logic is_high;
		logic is_low;
		logic paired;
		is_high = (u >= 16'hD800) && (u <= 16'hDBFF);
		is_low = (u >= 16'hDC00) && (u <= 16'hDFFF);
		paired = surr_held && is_low;
		if (paired)
			encode_point(21'h10000 + {1'b0, surr_bits, u[9:0]});
		else if (!is_high && !is_low)
			encode_point({5'd0, u});
		surr_held = is_high && !eot;
		surr_bits = surr_held ? u[9:0] : 10'd0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		utf8_out_t got;
		if (!arst_n) begin
			surr_held = 1'b0;
			surr_bits = '0;
		end else begin
			if (in_valid && !in_stall)
				predict_unit(code_unit, end_of_text);
			if (out_valid && !out_stall) begin
				if (owed_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h run_last %0b with nothing owed",
						utf8_byte, run_last));
				end else begin
					got = owed_bytes.pop_front();
					if (utf8_byte !== got.octet)
						report_mismatch($sformatf("utf8_byte %02h, want %02h",
							utf8_byte, got.octet));
					if (run_last !== got.last_flag)
						report_mismatch($sformatf("run_last %0b, want %0b on byte %02h",
							run_last, got.last_flag, got.octet));
				end
			end
		end
		bytes_due = owed_bytes.size();
	end

endmodule

// ===== sim/tb.sv =====
// Top of the transcoder testbench: clock, reset, code unit stimulus, output stalls
// and the verdict. Depends on utf16_to_utf8_transcoder_core and utt_stream_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        end_of_text;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  utf8_byte;
	logic        run_last;
	int          mismatches;
	int          bytes_due;
	int          calm_left = 0;
	int          units_sent = 0;

	utf16_to_utf8_transcoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.utf8_byte(utf8_byte),
		.run_last(run_last)
	);

	utt_stream_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.utf8_byte(utf8_byte),
		.run_last(run_last),
		.mismatches(mismatches),
		.bytes_due(bytes_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(15, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_unit(input logic [15:0] u, input logic eot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= u;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		units_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_text(input int target);
		int r;
		logic eot;
		logic [15:0] u;
		while (units_sent < target) begin
			r = $urandom_range(0, 99);
			eot = ($urandom_range(0, 7) == 0);
			if (r < 18) begin
				send_unit(16'($urandom_range(16'h0000, 16'h007F)), eot);
			end else if (r < 32) begin
				send_unit(16'($urandom_range(16'h0080, 16'h07FF)), eot);
			end else if (r < 46) begin
				if ($urandom_range(0, 1))
					u = 16'($urandom_range(16'h0800, 16'hD7FF));
				else
					u = 16'($urandom_range(16'hE000, 16'hFFFF));
				send_unit(u, eot);
			end else if (r < 72) begin
				send_unit(16'hD800 + 16'($urandom_range(0, 16'h03FF)), 1'b0);
				send_unit(16'hDC00 + 16'($urandom_range(0, 16'h03FF)), eot);
			end else if (r < 84) begin
				send_unit(16'($urandom_range(0, 16'hFFFF)), eot);
			end else if (r < 92) begin
				send_unit(16'hD800 + 16'($urandom_range(0, 16'h03FF)), eot);
			end else begin
				send_unit(16'hDC00 + 16'($urandom_range(0, 16'h03FF)), eot);
			end
		end
	endtask

	initial begin : out_side
		int r;
		int len;
		logic val;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				val = 1'b0;
				len = $urandom_range(1, 4);
			end else if (r < 85) begin
				val = 1'b1;
				len = $urandom_range(1, 3);
			end else if (r < 93) begin
				val = 1'b1;
				len = $urandom_range(8, 25);
			end else begin
				val = 1'b0;
				len = $urandom_range(20, 60);
			end
			@(negedge clk);
			out_stall <= val;
			repeat (len - 1) @(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		code_unit = '0;
		end_of_text = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hD7FF, 1'b0);
		send_unit(16'hE000, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		send_unit(16'hD900, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hDA00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDC05, 1'b0);
		send_unit(16'hD83D, 1'b1);
		send_unit(16'hDE00, 1'b0);
		send_unit(16'hD834, 1'b0);
		send_unit(16'hDD1E, 1'b1);
		send_unit(16'h0024, 1'b1);
		send_unit(16'h20AC, 1'b1);

		send_random_text(units_sent + 155);
		in_valid <= 1'b0;

		do
			@(negedge clk);
		while (bytes_due != 0);
		repeat (16) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
